@@ src/sorted_insert_and_merge_top_macros.svh @@
// assertion macros for the sorted insert and merge block
// used by sorted_insert_and_merge_top; expects a clock named clk and reset rst
`ifndef SORTED_INSERT_AND_MERGE_TOP_MACROS_SVH
`define SORTED_INSERT_AND_MERGE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define SIM_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sorted insert and merge: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SIM_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sorted insert and merge: next-cycle check failed");

`else

`define SIM_ASSERT_SAME(label, cond, prop)
`define SIM_ASSERT_NEXT(label, cond, prop)

`endif

`endif

@@ src/sim_pkg.sv @@
// shared types and constants for the sorted insert and merge block
// no dependencies; imported by sim_cell, sim_list and the top level
package sim_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int KEY_W      = 32;

  localparam logic [1:0] OP_INS_A = 2'd0;
  localparam logic [1:0] OP_INS_B = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_MERGED = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_MERGE
  } state_t;

  // broadcast command to every cell of one list
  typedef struct packed {
    logic                    ins;
    logic                    pop;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                    keep;
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } cell_link_t;

  // list status seen by the controller
  typedef struct packed {
    logic                    head_valid;
    logic signed [KEY_W-1:0] head_key;
    logic                    second_valid;
    logic                    full;
  } list_stat_t;

endpackage

@@ src/sorted_insert_and_merge_top.sv @@
// sorted insert and merge: two ascending key lists held in rows of shift-insert cells
// latency: an insert or empty-merge result is on the ports the cycle after acceptance
// merge of n keys: first key via the state and result registers, then one per cycle
// throughput: an insert every idle cycle, none while merging; results cannot stall
// reset (rst, synchronous) empties both lists and clears the result strobe
// depends on sim_pkg, sim_list, sim_cell and sorted_insert_and_merge_top_macros.svh
`include "sorted_insert_and_merge_top_macros.svh"

module sorted_insert_and_merge_top import sim_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              op,
  input  logic signed [KEY_W-1:0] key,
  output logic                    valid,
  output logic signed [KEY_W-1:0] key_out,
  output logic [1:0]              status,
  output logic                    last
);

  state_t state;
  state_t state_next;

  cell_cmd_t  cmd_a;
  cell_cmd_t  cmd_b;
  list_stat_t stat_a;
  list_stat_t stat_b;

  logic                    accept;
  logic                    run_start;
  logic                    take_a;
  logic                    final_pop;
  logic                    res_valid_next;
  logic signed [KEY_W-1:0] res_key_next;
  logic [1:0]              res_status_next;
  logic                    res_last_next;

  // one list per side, each a row of cells
  sim_list u_list_a (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_a),
    .stat (stat_a)
  );

  sim_list u_list_b (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd_b),
    .stat (stat_b)
  );

  assign busy   = (state == S_MERGE);
  assign accept = start && !busy;

  // a merge item with at least one key waiting starts a run of pops
  assign run_start = accept && (op == OP_MERGE) && (stat_a.head_valid || stat_b.head_valid);

  // head pick: list a wins ties
  assign take_a = stat_a.head_valid &&
                  (!stat_b.head_valid || ($signed(stat_a.head_key) <= $signed(stat_b.head_key)));

  // exactly one key left across both lists
  assign final_pop = (stat_a.head_valid && !stat_a.second_valid && !stat_b.head_valid) ||
                     (stat_b.head_valid && !stat_b.second_valid && !stat_a.head_valid);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (run_start) begin
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        if (final_pop) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // cell commands and the result for the coming cycle
  always_comb begin
    cmd_a           = '{ins: 1'b0, pop: 1'b0, key: key};
    cmd_b           = '{ins: 1'b0, pop: 1'b0, key: key};
    res_valid_next  = 1'b0;
    res_key_next    = '0;
    res_status_next = ST_OK;
    res_last_next   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_INS_A: begin
              res_valid_next  = 1'b1;
              cmd_a.ins       = !stat_a.full;
              res_status_next = stat_a.full ? ST_FULL : ST_OK;
            end
            OP_INS_B: begin
              res_valid_next  = 1'b1;
              cmd_b.ins       = !stat_b.full;
              res_status_next = stat_b.full ? ST_FULL : ST_OK;
            end
            OP_MERGE: begin
              // both empty gives the empty status, otherwise the run starts next cycle
              res_valid_next  = !(stat_a.head_valid || stat_b.head_valid);
              res_status_next = ST_EMPTY;
            end
            default: begin
              // unused op: dropped without a result
              res_valid_next = 1'b0;
            end
          endcase
        end
      end
      S_MERGE: begin
        cmd_a.pop       = take_a;
        cmd_b.pop       = !take_a;
        res_valid_next  = 1'b1;
        res_key_next    = take_a ? stat_a.head_key : stat_b.head_key;
        res_status_next = ST_MERGED;
        res_last_next   = final_pop;
      end
      default: begin
        res_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= res_valid_next;
    end
  end

  // result payload, meaningful only with valid
  always_ff @(posedge clk) begin
    key_out <= res_key_next;
    status  <= res_status_next;
    last    <= res_last_next;
  end

  // a merge in progress always has a key left to emit
  `SIM_ASSERT_SAME(a_merge_has_key, busy, stat_a.head_valid || stat_b.head_valid)
  // an insert or an empty merge yields its result in the next cycle
  `SIM_ASSERT_NEXT(a_accept_result, accept && (op != OP_NONE) && !run_start, valid)
  // every merge cycle pops a key that shows on the ports in the next cycle
  `SIM_ASSERT_NEXT(a_merge_streams, busy, valid)
  // the final merged key leaves the block idle
  `SIM_ASSERT_SAME(a_last_idle, valid && last && (status == ST_MERGED), !busy)

endmodule

@@ src/sim_cell.sv @@
// one cell of a sorted list: holds one key and its valid bit
// depends on sim_pkg
module sim_cell import sim_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic                    valid;
  logic signed [KEY_W-1:0] key;
  logic                    keep;

  // strictly smaller keys stay put, so a new key lands ahead of equal ones
  assign keep = valid && ($signed(key) < $signed(cmd.key));

  assign link.keep  = keep;
  assign link.valid = valid;
  assign link.key   = key;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      if (!keep) begin
        valid <= left.keep ? 1'b1 : left.valid;
      end
    end else if (cmd.pop) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (!keep) begin
        key <= left.keep ? cmd.key : left.key;
      end
    end else if (cmd.pop) begin
      key <= right.key;
    end
  end

endmodule

@@ src/sim_list.sv @@
// row of sim_cell instances forming one bounded ascending list
// depends on sim_pkg and sim_cell
module sim_list import sim_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  output list_stat_t stat
);

  cell_link_t links [LIST_DEPTH];

  localparam cell_link_t HEAD_EDGE = '{keep: 1'b1, valid: 1'b0, key: '0};
  localparam cell_link_t TAIL_EDGE = '{keep: 1'b0, valid: 1'b0, key: '0};

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    cell_link_t left_link;
    cell_link_t right_link;

    if (i == 0) begin : g_first
      assign left_link = HEAD_EDGE;
    end else begin : g_mid_l
      assign left_link = links[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_link = TAIL_EDGE;
    end else begin : g_mid_r
      assign right_link = links[i+1];
    end

    sim_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  (left_link),
      .right (right_link),
      .link  (links[i])
    );
  end

  assign stat.head_valid = links[0].valid;
  assign stat.head_key   = links[0].key;
  assign stat.full       = links[LIST_DEPTH-1].valid;

  if (LIST_DEPTH > 1) begin : g_second
    assign stat.second_valid = links[1].valid;
  end else begin : g_no_second
    assign stat.second_valid = 1'b0;
  end

endmodule

@@ verif/tb.sv @@
// testbench for sorted_insert_and_merge_top: directed, full-list, random and back-to-back traffic
// predicts every result from its own copy of both key lists and checks each strobed result
// depends on sim_pkg and the rtl of sorted_insert_and_merge_top
`timescale 1ns / 1ps

module tb import sim_pkg::*; ();

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run
  localparam int DRAIN_CYCLES = 80;      // longer than one full merge of both lists
  localparam int MAX_REPORTS  = 10;

  // one result as seen on the result ports
  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    logic [1:0]              status;
    logic                    last;
  } result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              op = OP_INS_A;
  logic signed [KEY_W-1:0] key = '0;
  logic                    busy;
  logic                    valid;
  logic signed [KEY_W-1:0] key_out;
  logic [1:0]              status;
  logic                    last;

  // shadow copies of both lists, always kept in ascending order
  logic signed [KEY_W-1:0] shadow_a[$];
  logic signed [KEY_W-1:0] shadow_b[$];

  // results that are predicted but not yet seen, oldest first
  result_t pending_results[$];

  bit no_gaps = 1'b0;
  int fault_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int merged_keys = 0;
  int full_answers = 0;
  int empty_merges = 0;

  sorted_insert_and_merge_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .op      (op),
    .key     (key),
    .valid   (valid),
    .key_out (key_out),
    .status  (status),
    .last    (last)
  );

  always #6 clk = ~clk;

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void expect_result(input logic signed [KEY_W-1:0] k,
                                        input logic [1:0] s, input logic l);
    result_t r;
    r.key_out = k;
    r.status  = s;
    r.last    = l;
    pending_results.push_back(r);
  endfunction

  // sorted insert into one shadow list; the new key goes ahead of equal keys
  function automatic logic [1:0] shadow_insert(input bit to_b,
                                               input logic signed [KEY_W-1:0] k);
    int pos = 0;
    if (to_b) begin
      if (shadow_b.size() >= LIST_DEPTH) return ST_FULL;
      while (pos < shadow_b.size() && k > shadow_b[pos]) pos++;
      shadow_b.insert(pos, k);
    end else begin
      if (shadow_a.size() >= LIST_DEPTH) return ST_FULL;
      while (pos < shadow_a.size() && k > shadow_a[pos]) pos++;
      shadow_a.insert(pos, k);
    end
    return ST_OK;
  endfunction

  // two-way merge of the shadow lists, list a wins ties, then both are emptied
  function automatic void shadow_merge();
    int ia = 0;
    int ib = 0;
    int total;
    int n = 0;
    logic signed [KEY_W-1:0] v;
    total = shadow_a.size() + shadow_b.size();
    if (total == 0) begin
      expect_result('0, ST_EMPTY, 1'b1);
      return;
    end
    while (ia < shadow_a.size() || ib < shadow_b.size()) begin
      if (ib >= shadow_b.size() || (ia < shadow_a.size() && shadow_a[ia] <= shadow_b[ib])) begin
        v = shadow_a[ia];
        ia++;
      end else begin
        v = shadow_b[ib];
        ib++;
      end
      n++;
      expect_result(v, ST_MERGED, n == total);
    end
    shadow_a.delete();
    shadow_b.delete();
  endfunction

  // work out every result that one accepted item causes
  function automatic void predict_item(input logic [1:0] o, input logic signed [KEY_W-1:0] k);
    case (o)
      OP_INS_A: expect_result('0, shadow_insert(1'b0, k), 1'b1);
      OP_INS_B: expect_result('0, shadow_insert(1'b1, k), 1'b1);
      OP_MERGE: shadow_merge();
      default: ;  // unused op: no result, no change
    endcase
  endfunction

  // key mix: full range, a narrow band around zero for ties, the extremes and keys next to them
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6: return $signed($urandom_range(0, 16)) - 8;
      7: return {1'b1, {(KEY_W-1){1'b0}}};
      8: return {1'b0, {(KEY_W-1){1'b1}}};
      default: return $urandom_range(0, 1) ? {1'b1, {(KEY_W-2){1'b0}}, 1'b1}
                                           : {1'b0, {(KEY_W-2){1'b1}}, 1'b0};
    endcase
  endfunction

  // send one item; start stays high on return so the next item can follow directly
  task automatic send_item(input logic [1:0] o, input logic signed [KEY_W-1:0] k);
    int gap;
    if (!no_gaps && $urandom_range(0, 99) < 34) begin
      gap = $urandom_range(1, 3);
      // idle cycles carry junk on op and key, which must be ignored
      start <= 1'b0;
      op    <= 2'($urandom_range(0, 3));
      key   <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op    <= o;
    key   <= k;
    do @(posedge clk); while (busy !== 1'b0);
    // accepted at this edge
    items_sent++;
    predict_item(o, k);
  endtask

  task automatic report_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("error at %0t: %s", $realtime, what);
  endtask

  // result checker: every strobed result against the oldest prediction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && valid === 1'b1) begin
      got.key_out = key_out;
      got.status  = status;
      got.last    = last;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_fault($sformatf("result with none expected: key_out %0d status %0d last %0d",
                               got.key_out, got.status, got.last));
      end else begin
        want = pending_results.pop_front();
        case (want.status)
          ST_MERGED: merged_keys++;
          ST_FULL:   full_answers++;
          ST_EMPTY:  empty_merges++;
          default: ;
        endcase
        if (got !== want)
          report_fault($sformatf({"expected key_out %0d status %0d last %0d, ",
                                  "got key_out %0d status %0d last %0d"},
                                 want.key_out, want.status, want.last,
                                 got.key_out, got.status, got.last));
      end
    end
  end

  // extremes of the key, ties across lists, one list empty, both empty, unused op
  task automatic test_directed();
    send_item(OP_MERGE, '0);                       // both lists empty
    send_item(OP_NONE, 32'sh1234_5678);            // ignored
    send_item(OP_INS_A, 32'sh7FFF_FFFF);
    send_item(OP_INS_A, 32'sh8000_0000);
    send_item(OP_INS_A, 32'sh0000_0000);
    send_item(OP_INS_A, -32'sd1);
    send_item(OP_INS_A, 32'sh0000_0000);           // duplicate within a list
    send_item(OP_INS_B, 32'sh0000_0000);           // tie with list a
    send_item(OP_INS_B, 32'sh8000_0000);
    send_item(OP_INS_B, 32'sh7FFF_FFFF);
    send_item(OP_INS_B, 32'sd1);
    send_item(OP_NONE, -32'sd1);
    send_item(OP_MERGE, '0);
    send_item(OP_MERGE, 32'sh7FFF_FFFF);           // empty again after a merge
    send_item(OP_INS_B, 32'sd5);
    send_item(OP_INS_B, -32'sd5);
    send_item(OP_MERGE, '0);                       // only list b holds keys
    send_item(OP_INS_A, 32'sd3);
    send_item(OP_MERGE, '0);                       // only list a holds keys
    send_item(OP_INS_A, 32'sh5555_5555);
    send_item(OP_INS_B, 32'shAAAA_AAAA);
    send_item(OP_MERGE, '0);
  endtask

  // fill both lists to capacity, overflow each, then merge the longest run
  task automatic test_full_lists();
    send_item(OP_MERGE, '0);
    repeat (LIST_DEPTH + 2) send_item(OP_INS_A, pick_key());
    repeat (LIST_DEPTH + 1) send_item(OP_INS_B, pick_key());
    send_item(OP_MERGE, '0);
  endtask

  // mostly runs of inserts closed by a merge, a little unused-op noise
  task automatic test_random_traffic(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 44)      send_item(OP_INS_A, pick_key());
      else if (pick < 88) send_item(OP_INS_B, pick_key());
      else if (pick < 97) send_item(OP_MERGE, $urandom);
      else                send_item(OP_NONE, $urandom);
    end
  endtask

  // same traffic with start held high: items follow each other every free cycle
  task automatic test_back_to_back(input int count);
    no_gaps = 1'b1;
    test_random_traffic(count);
    send_item(OP_MERGE, '0);
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_full_lists();
    test_random_traffic(280);
    test_back_to_back(100);
    send_item(OP_MERGE, '0);

    // stimulus done: let every predicted result arrive, then watch for strays
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results", items_sent, results_seen);
    $display("merged keys %0d, full answers %0d, empty merges %0d, errors %0d",
             merged_keys, full_answers, empty_merges, fault_count);
    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
